### rtl/dfmt_pkg.sv
//------------------------------------------------------------------------------
// dfmt_pkg
// Shared types and constants of the decimal field formatter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfmt_pkg;

  // Largest field width or precision; larger requests saturate to it.
  localparam int MAX_WIDTH = 32;
  localparam int LEN_W     = $clog2(MAX_WIDTH + 1);

  localparam int VALUE_W = 63;
  localparam int DIGITS  = 19;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int ND_W    = $clog2(DIGITS + 1);
  localparam int DIG_W   = $clog2(DIGITS);
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int FLAG_LEFT = 0;
  localparam int FLAG_ZERO = 1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         pad_flags;
    logic [5:0]         field_width;
    logic [5:0]         min_digits;
    logic               precision_given;
  } num_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } chr_word_t;

  // Layout of one formatted field, handed from the sequencer to the emitter.
  typedef struct packed {
    logic             left;
    logic [7:0]       padc;
    logic [LEN_W-1:0] body;
    logic [LEN_W-1:0] pads;
    logic [LEN_W-1:0] total;
  } job_t;

endpackage

### rtl/dfmt_bcd_conv.sv
//------------------------------------------------------------------------------
// dfmt_bcd_conv
// Binary to BCD converter: one shift-and-add-3 step per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfmt_bcd_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dfmt_pkg::VALUE_W-1:0] bin,
  output logic                         busy,
  output logic [dfmt_pkg::BCD_W-1:0]   bcd
);
  import dfmt_pkg::*;

  logic [VALUE_W-1:0] sh;
  logic [CNT_W-1:0]   cnt;
  logic [BCD_W-1:0]   bcd_adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= bin;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], sh[VALUE_W-1]};
      sh  <= {sh[VALUE_W-2:0], 1'b0};
    end
  end

endmodule

### rtl/dfmt_emit.sv
//------------------------------------------------------------------------------
// dfmt_emit
// Character emitter: walks the field one character per word into an output
// register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfmt_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  dfmt_pkg::job_t             job,
  input  logic [dfmt_pkg::BCD_W-1:0] bcd,
  output logic                       busy,
  output logic                       chr_valid,
  input  logic                       chr_stall,
  output dfmt_pkg::chr_word_t        chr
);
  import dfmt_pkg::*;

  job_t             cur;
  logic             active;
  logic [LEN_W-1:0] k;
  logic             load;
  logic             in_body;
  logic [LEN_W-1:0] d;
  logic [3:0]       dig;
  logic [7:0]       ch;
  logic             is_last;

  assign load    = !chr_valid || !chr_stall;
  assign busy    = active || chr_valid;
  assign is_last = (k == cur.total - 1'b1);

  always_comb begin
    if (cur.left) begin
      in_body = (k < cur.body);
      d       = cur.body - 1'b1 - k;
    end else begin
      in_body = (k >= cur.pads);
      d       = cur.total - 1'b1 - k;
    end
    // Positions above the converted digits are leading zeros.
    if (d < LEN_W'(DIGITS)) begin
      dig = bcd[4*d[DIG_W-1:0] +: 4];
    end else begin
      dig = 4'd0;
    end
    if (in_body) begin
      ch = CHAR_ZERO + {4'd0, dig};
    end else if (cur.left) begin
      ch = CHAR_SPACE;
    end else begin
      ch = cur.padc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      chr_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (start) begin
        active <= 1'b1;
        k      <= '0;
      end else if (active && load) begin
        k <= k + 1'b1;
        if (is_last) begin
          active <= 1'b0;
        end
      end
      if (load) begin
        chr_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= job;
    end
    if (active && load) begin
      chr.char_out <= ch;
      chr.last     <= is_last;
    end
  end

endmodule

### rtl/decimal_field_formatter.sv
//------------------------------------------------------------------------------
// decimal_field_formatter
// Formats a non-negative integer as a padded decimal ASCII field.
//------------------------------------------------------------------------------
// Path from an accepted word to the first character on chr: the converter steps,
// one per value bit, a state that sees the converter finish, a digit count, a
// sizing step and the load of the output register.
// Input: num_stall holds each next word off until the field (1 to 32 characters)
// has left on chr, stalls included; an empty field frees the input after sizing.
// Reset (rst, synchronous) returns the sequencer to idle and drops chr_valid.
`timescale 1ns / 1ps

module decimal_field_formatter (
  input  logic                clk,
  input  logic                rst,
  input  logic                num_valid,
  output logic                num_stall,
  input  dfmt_pkg::num_word_t num,
  output logic                chr_valid,
  input  logic                chr_stall,
  output dfmt_pkg::chr_word_t chr
);
  import dfmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_COUNT,
    S_SIZE,
    S_EMIT
  } state_t;

  state_t           state;
  logic             accept;
  logic             left;
  logic [7:0]       padc;
  logic [LEN_W-1:0] width;
  logic [LEN_W-1:0] prec;
  logic [ND_W-1:0]  nd;
  logic [ND_W-1:0]  nd_next;
  logic [LEN_W-1:0] width_next;
  logic [LEN_W-1:0] prec_next;
  logic             conv_busy;
  logic [BCD_W-1:0] bcd;
  logic             emit_busy;
  logic             emit_start;
  job_t             job;

  assign num_stall = (state != S_IDLE);
  assign accept    = num_valid && !num_stall;

  always_comb begin
    if (num.field_width > LEN_W'(MAX_WIDTH)) begin
      width_next = LEN_W'(MAX_WIDTH);
    end else begin
      width_next = num.field_width;
    end
    if (!num.precision_given) begin
      prec_next = LEN_W'(1);
    end else if (num.min_digits > LEN_W'(MAX_WIDTH)) begin
      prec_next = LEN_W'(MAX_WIDTH);
    end else begin
      prec_next = num.min_digits;
    end
  end

  // Digit count: one past the highest nonzero BCD digit.
  always_comb begin
    nd_next = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        nd_next = ND_W'(i + 1);
      end
    end
  end

  always_comb begin
    job.left = left;
    job.padc = padc;
    if (LEN_W'(nd) > prec) begin
      job.body = LEN_W'(nd);
    end else begin
      job.body = prec;
    end
    if (width > job.body) begin
      job.pads = width - job.body;
    end else begin
      job.pads = '0;
    end
    job.total = job.pads + job.body;
  end

  assign emit_start = (state == S_SIZE) && (job.total != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
            left  <= num.pad_flags[FLAG_LEFT];
            padc  <= (num.pad_flags[FLAG_ZERO] && !num.precision_given) ?
                     CHAR_ZERO : CHAR_SPACE;
            width <= width_next;
            prec  <= prec_next;
          end
        end
        S_CONV: begin
          if (!conv_busy) begin
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          nd    <= nd_next;
          state <= S_SIZE;
        end
        S_SIZE: begin
          // An empty field produces no word at all.
          state <= emit_start ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dfmt_bcd_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .bin   (num.value),
    .busy  (conv_busy),
    .bcd   (bcd)
  );

  dfmt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (emit_start),
    .job       (job),
    .bcd       (bcd),
    .busy      (emit_busy),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

endmodule
